// ===== rtl/core/qprh_pkg.sv =====
// Shared types, constants and helpers for the polynomial rolling hash queue.
// Used by every module under rtl/core except qprh_ram; depends on nothing else.
`default_nettype none

package qprh_pkg;

  // Queue geometry
  localparam int unsigned QueueDepth  = 16;
  localparam int unsigned IdxW        = $clog2(QueueDepth);
  localparam int unsigned CntW        = $clog2(QueueDepth + 1);

  // Field widths
  localparam int unsigned ValueW      = 31;
  localparam int unsigned HashW       = 30;
  localparam int unsigned EntryCountW = 5;

  // Depth of the command queue between front and back end
  localparam int unsigned CmdDepth    = 2;

  // Hash arithmetic constants
  localparam logic [HashW-1:0] HashMod  = 30'd1000000009;
  localparam logic [HashW-1:0] HashBase = 30'd31;
  localparam logic [HashW-1:0] BaseInv  = 30'd838709685;

  // Barrett constant floor(2^60 / modulus), fits in 31 bits
  localparam int unsigned      MuW        = 31;
  localparam logic [MuW-1:0]   BarrettMu  = MuW'((64'd1 << 60) / 64'(HashMod));

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_REMOVE = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_PASS   = 2'd2
  } cmd_e;

  typedef struct packed {
    func_e             func;
    logic [ValueW-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [HashW-1:0]       hash_value;
    logic [EntryCountW-1:0] entry_count;
    status_e                status;
  } out_item_t;

  // Classified work for the back end
  typedef struct packed {
    cmd_e                   kind;
    logic [HashW-1:0]       operand;
    logic [EntryCountW-1:0] count;
    status_e                status;
  } cmd_t;

  // Reduce a 31-bit value mod the hash modulus (value < 3 * modulus)
  function automatic logic [HashW-1:0] reduce_value(input logic [ValueW-1:0] v);
    logic [ValueW-1:0] m1;
    logic [ValueW-1:0] m2;
    logic [ValueW-1:0] r;
    m1 = ValueW'(HashMod);
    m2 = m1 << 1;
    if (v >= m2) begin
      r = v - m2;
    end else if (v >= m1) begin
      r = v - m1;
    end else begin
      r = v;
    end
    return r[HashW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/qprh_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module qprh_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [$clog2(Depth)-1:0]   waddr_i,
  input  wire logic [Width-1:0]           wdata_i,
  input  wire logic [$clog2(Depth)-1:0]   raddr_i,
  output logic      [Width-1:0]           rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/core/qprh_modmul.sv =====
// Four-stage pipelined modular multiplier (Barrett reduction) for the hash modulus.
// Depends on qprh_pkg.
`default_nettype none

module qprh_modmul (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [qprh_pkg::HashW-1:0] a_i,
  input  wire logic [qprh_pkg::HashW-1:0] b_i,
  output logic                            done_o,
  output logic      [qprh_pkg::HashW-1:0] res_o
);

  import qprh_pkg::*;

  localparam int unsigned ProdW = 2 * HashW;
  localparam int unsigned Q1W   = ProdW - (HashW - 1);
  localparam int unsigned TW    = Q1W + MuW;
  localparam int unsigned RemW  = 32;

  logic                 v1_q, v2_q, v3_q, v4_q;
  logic [ProdW-1:0]     prod_d, prod_q;
  logic [Q1W-1:0]       q1;
  logic [TW-1:0]        t_d, t_q;
  logic [Q1W-1:0]       q3;
  logic [RemW-1:0]      qm_d, qm_q;
  logic [RemW-1:0]      plo1_q, plo2_q;
  logic [RemW-1:0]      rem;
  logic [RemW-1:0]      mod1, mod2;
  logic [HashW-1:0]     res_d, res_q;

  // Stage 1: full product
  assign prod_d = ProdW'(a_i) * ProdW'(b_i);

  // Stage 2: quotient estimate from the top bits
  assign q1  = prod_q[ProdW-1:HashW-1];
  assign t_d = TW'(q1) * TW'(BarrettMu);

  // Stage 3: quotient times modulus, low word only
  assign q3   = t_q[TW-1:HashW+1];
  assign qm_d = RemW'(q3) * RemW'(HashMod);

  // Stage 4: remainder is below three moduli, fix up with two compares
  assign mod1 = RemW'(HashMod);
  assign mod2 = mod1 << 1;
  assign rem  = plo2_q - qm_q;

  always_comb begin
    if (rem >= mod2) begin
      res_d = HashW'(rem - mod2);
    end else if (rem >= mod1) begin
      res_d = HashW'(rem - mod1);
    end else begin
      res_d = HashW'(rem);
    end
  end

  // Advance stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= prod_d;
    end
    if (v1_q) begin
      t_q    <= t_d;
      plo1_q <= prod_q[RemW-1:0];
    end
    if (v2_q) begin
      qm_q   <= qm_d;
      plo2_q <= plo1_q;
    end
    if (v3_q) begin
      res_q  <= res_d;
    end
  end

  assign done_o = v4_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

// ===== rtl/core/qprh_fifo.sv =====
// Short command queue between the front end and the back end.
// Depends on qprh_pkg.
`default_nettype none

module qprh_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire qprh_pkg::cmd_t push_cmd_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output qprh_pkg::cmd_t      head_o
);

  import qprh_pkg::*;

  localparam int unsigned PtrW  = (CmdDepth > 1) ? $clog2(CmdDepth) : 1;
  localparam int unsigned FillW = $clog2(CmdDepth + 1);

  cmd_t             slot_q [CmdDepth];
  logic [PtrW-1:0]  wr_ptr_d, wr_ptr_q;
  logic [PtrW-1:0]  rd_ptr_d, rd_ptr_q;
  logic [FillW-1:0] fill_d, fill_q;

  assign full_o  = (fill_q == FillW'(CmdDepth));
  assign empty_o = (fill_q == '0);
  assign head_o  = slot_q[rd_ptr_q];

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(CmdDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(CmdDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + 1'b1;
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Store pushed commands
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("command pushed into full queue");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/qprh_front.sv =====
// Front end: accepts items, tracks queue occupancy, owns the value store and
// classifies each item into a command for the back end. Depends on qprh_pkg, qprh_ram.
`default_nettype none

module qprh_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire qprh_pkg::in_item_t in_item_i,
  output logic                    push_o,
  output qprh_pkg::cmd_t          push_cmd_o,
  input  wire logic               fifo_full_i
);

  import qprh_pkg::*;

  localparam logic FrIdle = 1'b0;
  localparam logic FrRead = 1'b1;

  logic                st_d, st_q;
  logic [IdxW-1:0]     head_d, head_q;
  logic [IdxW-1:0]     tail_d, tail_q;
  logic [CntW-1:0]     count_d, count_q;
  logic                accept;
  logic                ram_we;
  logic [ValueW-1:0]   ram_rdata;

  assign in_stall_o = (st_q != FrIdle) || fifo_full_i;
  assign accept     = in_valid_i && !in_stall_o;

  qprh_ram #(
    .Width (ValueW),
    .Depth (QueueDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (in_item_i.value),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  // Classify the item and update occupancy
  always_comb begin
    st_d       = st_q;
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    ram_we     = 1'b0;
    push_o     = 1'b0;
    push_cmd_o = '{kind: CMD_PASS, operand: '0,
                   count: EntryCountW'(count_q), status: STAT_DONE};
    unique case (st_q)
      FrIdle: begin
        if (accept) begin
          if (in_item_i.func == FUNC_INSERT) begin
            push_o = 1'b1;
            if (count_q == CntW'(QueueDepth)) begin
              push_cmd_o.status = STAT_FULL;
            end else begin
              ram_we             = 1'b1;
              tail_d             = (tail_q == IdxW'(QueueDepth - 1)) ? '0 : tail_q + 1'b1;
              count_d            = count_q + 1'b1;
              push_cmd_o.kind    = CMD_INSERT;
              push_cmd_o.operand = reduce_value(in_item_i.value);
              push_cmd_o.count   = EntryCountW'(count_d);
            end
          end else begin
            if (count_q == '0) begin
              push_o            = 1'b1;
              push_cmd_o.status = STAT_EMPTY;
            end else begin
              // Head value comes out of the store next cycle
              head_d  = (head_q == IdxW'(QueueDepth - 1)) ? '0 : head_q + 1'b1;
              count_d = count_q - 1'b1;
              st_d    = FrRead;
            end
          end
        end
      end
      FrRead: begin
        push_o             = 1'b1;
        push_cmd_o.kind    = CMD_REMOVE;
        push_cmd_o.operand = reduce_value(ram_rdata);
        st_d               = FrIdle;
      end
      default: begin
        st_d = FrIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= FrIdle;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      st_q    <= st_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QueueDepth))
    else $error("occupancy above queue depth");
  a_remove_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_item_i.func == FUNC_REMOVE && count_q != '0) |=> (st_q == FrRead))
    else $error("remove did not read the store");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/qprh_back.sv =====
// Back end: applies commands to the running hash and power with two modular
// multipliers and holds the result item. Depends on qprh_pkg, qprh_modmul.
`default_nettype none

module qprh_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cmd_empty_i,
  input  wire qprh_pkg::cmd_t      cmd_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output qprh_pkg::out_item_t      out_item_o
);

  import qprh_pkg::*;

  localparam logic [1:0] BkIdle = 2'd0;
  localparam logic [1:0] BkPrep = 2'd1;
  localparam logic [1:0] BkMul  = 2'd2;
  localparam logic [1:0] BkFin  = 2'd3;

  logic [1:0]       st_d, st_q;
  cmd_t             cmd_q;
  logic [HashW-1:0] hash_d, hash_q;
  logic [HashW-1:0] pow_d, pow_q;
  logic [HashW-1:0] ha_q, hb_q, pa_q, pb_q;
  logic             start_q;
  logic             done_h, done_p;
  logic [HashW-1:0] res_h, res_p;
  logic [HashW-1:0] diff;
  logic [HashW:0]   sum;
  logic             fin_fire;
  logic             out_valid_q;
  out_item_t        out_item_q;

  qprh_modmul u_mul_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .a_i     (ha_q),
    .b_i     (hb_q),
    .done_o  (done_h),
    .res_o   (res_h)
  );

  qprh_modmul u_mul_pow (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .a_i     (pa_q),
    .b_i     (pb_q),
    .done_o  (done_p),
    .res_o   (res_p)
  );

  // Head value subtracted from hash, kept in range
  assign diff = (hash_q >= cmd_q.operand) ? hash_q - cmd_q.operand
              : HashW'((HashW+1)'(hash_q) + (HashW+1)'(HashMod)
                       - (HashW+1)'(cmd_q.operand));

  // Hash plus new term for an insert
  assign sum = (HashW+1)'(hash_q) + (HashW+1)'(res_h);

  assign pop_o    = (st_q == BkIdle) && !cmd_empty_i;
  assign fin_fire = (st_q == BkFin) && (!out_valid_q || !out_stall_i);

  // New hash and power for the finishing command
  always_comb begin
    hash_d = hash_q;
    pow_d  = pow_q;
    unique case (cmd_q.kind)
      CMD_INSERT: begin
        hash_d = (sum >= (HashW+1)'(HashMod)) ? HashW'(sum - (HashW+1)'(HashMod))
                                               : HashW'(sum);
        pow_d  = res_p;
      end
      CMD_REMOVE: begin
        hash_d = res_h;
        pow_d  = res_p;
      end
      default: begin
        hash_d = hash_q;
        pow_d  = pow_q;
      end
    endcase
  end

  // Sequence one command at a time
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      BkIdle: begin
        if (!cmd_empty_i) begin
          st_d = (cmd_i.kind == CMD_PASS) ? BkFin : BkPrep;
        end
      end
      BkPrep: begin
        st_d = BkMul;
      end
      BkMul: begin
        if (done_h && done_p) begin
          st_d = BkFin;
        end
      end
      BkFin: begin
        if (fin_fire) begin
          st_d = BkIdle;
        end
      end
      default: begin
        st_d = BkIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= BkIdle;
      start_q     <= 1'b0;
      hash_q      <= '0;
      pow_q       <= HashW'(1);
      out_valid_q <= 1'b0;
    end else begin
      st_q    <= st_d;
      start_q <= (st_q == BkPrep);
      if (fin_fire) begin
        hash_q <= hash_d;
        pow_q  <= pow_d;
      end
      // Hold the result until the receiver takes it
      if (fin_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture command, set up multiplier operands, load result
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= cmd_i;
    end
    if (st_q == BkPrep) begin
      pa_q <= pow_q;
      if (cmd_q.kind == CMD_INSERT) begin
        ha_q <= cmd_q.operand;
        hb_q <= pow_q;
        pb_q <= HashBase;
      end else begin
        ha_q <= diff;
        hb_q <= BaseInv;
        pb_q <= BaseInv;
      end
    end
    if (fin_fire) begin
      out_item_q.hash_value  <= hash_d;
      out_item_q.entry_count <= cmd_q.count;
      out_item_q.status      <= cmd_q.status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef NO_ASSERTIONS
  a_hash_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.hash_value < HashMod))
    else $error("result hash not reduced");
  a_pow_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pow_q != '0) && (pow_q < HashMod))
    else $error("running power out of range");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/queue_polynomial_rolling_hash.sv =====
// Bounded FIFO of values with a polynomial rolling hash (base 31, mod 1000000009).
// Top level; depends on qprh_pkg, qprh_front, qprh_fifo, qprh_back.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i) takes one item: func
//   selects insert at tail or remove from front; value is appended on insert.
//   Output channel (out_valid_o / out_stall_i / out_item_o) returns exactly one
//   result per item: hash of the contents, entry count and status.
//   An item moves when valid is high and stall is low at a rising clock edge.
// Path: the front end classifies an accepted item and pushes a command; a
//   remove first reads its value from the store. Ignored items skip the multipliers.
// The back end takes one command at a time: it sets up operands, runs a
//   four-stage Barrett modular multiplier pair, finishes and loads the result
//   register; it takes no new command before the last one has finished.
// The front end accepts further items into a two-entry command queue while the
//   back end works or while a finished result waits in the output register.
// Reset (rst_ni low, asynchronous) empties the queue: hash 0, power 1, count 0.
// When the receiver stalls, the result holds; the command queue fills and then
//   in_stall_o rises.
`default_nettype none

module queue_polynomial_rolling_hash (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire qprh_pkg::in_item_t  in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output qprh_pkg::out_item_t      out_item_o
);

  import qprh_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic fifo_full;
  logic fifo_empty;
  logic pop;
  cmd_t head_cmd;

  qprh_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .push_o      (push),
    .push_cmd_o  (push_cmd),
    .fifo_full_i (fifo_full)
  );

  qprh_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (fifo_full),
    .pop_i      (pop),
    .empty_o    (fifo_empty),
    .head_o     (head_cmd)
  );

  qprh_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (fifo_empty),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire
